// ===== rtl/core/gpac_pkg.sv =====
// ----------------------------------------------------------------------------
// gpac_pkg
// Shared types and constants for the graphics memory port address counter.
// ----------------------------------------------------------------------------
package gpac_pkg;

    // Store size follows from this; the address counter itself is always 16 bits.
    localparam int ADDR_BITS  = 16;
    localparam int STORE_SIZE = 2 ** ADDR_BITS;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;
    localparam logic PORT_DATA  = 1'b0;
    localparam logic PORT_ADDR  = 1'b1;

    localparam logic [15:0] ADDR_KEEP_MASK = 16'hE000;
    localparam logic [15:0] ADDR_WRAP_MASK = 16'h1FFF;
    localparam logic [15:0] HIGH_MASK      = 16'hFF00;
    localparam logic [15:0] LOW_MASK       = 16'h00FF;

    localparam logic [4:0] COST_DATA_READ       = 5'd19;
    localparam logic [4:0] COST_ADDR_READ       = 5'd13;
    localparam logic [4:0] COST_DATA_WRITE      = 5'd22;
    localparam logic [4:0] COST_ADDR_WRITE_HIGH = 5'd15;
    localparam logic [4:0] COST_ADDR_WRITE_LOW  = 5'd21;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic commit;
    } gpac_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_full;
    } gpac_status_t;

endpackage

// ===== rtl/core/gpac_ctrl.sv =====
// ----------------------------------------------------------------------------
// gpac_ctrl
// Two-state sequencer: take a beat, then commit it once the output is free.
// ----------------------------------------------------------------------------
module gpac_ctrl
    import gpac_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic         m_tready,
    input  gpac_status_t status,
    output gpac_cmd_t    cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready    = (state_reg == ST_IDLE);
    assign cmd.capture = s_tvalid && (state_reg == ST_IDLE);
    // The result may be committed when the output register is empty or drains now.
    assign cmd.commit  = (state_reg == ST_EXEC) && (!status.out_full || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.capture) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (cmd.commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    cmd_only_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |-> !cmd.commit)
        else $error("capture and commit in the same cycle");
    exec_after_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (state_reg == ST_EXEC))
        else $error("capture did not start execution");
    idle_after_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> s_tready)
        else $error("not ready after commit");

endmodule

// ===== rtl/core/gpac_datapath.sv =====
// ----------------------------------------------------------------------------
// gpac_datapath
// Address counter, byte flags, byte store and output register.
// ----------------------------------------------------------------------------
module gpac_datapath
    import gpac_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  gpac_cmd_t    cmd,
    output gpac_status_t status,
    input  logic         in_kind,
    input  logic         in_port,
    input  logic [7:0]   in_write_byte,
    input  logic         m_tready,
    output logic         out_valid,
    output logic [7:0]   out_read_byte,
    output logic [4:0]   out_wait_cost
);

    logic [7:0] store_mem [STORE_SIZE];

    logic       kind_reg;
    logic       port_reg;
    logic [7:0] wbyte_reg;
    logic [7:0] rdata_reg;

    logic [15:0] addr_reg;
    logic [15:0] addr_next;
    logic        read_high_reg;
    logic        read_high_next;
    logic        write_high_reg;
    logic        write_high_next;

    logic        out_valid_reg;
    logic [7:0]  rbyte_reg;
    logic [7:0]  rbyte_next;
    logic [4:0]  cost_reg;
    logic [4:0]  cost_next;

    logic [15:0] addr_plus;
    logic [15:0] addr_step;

    assign addr_plus = addr_reg + 16'd1;
    // Data accesses wrap within the low 13 bits and keep the top three.
    assign addr_step = (addr_reg & ADDR_KEEP_MASK) | (addr_plus & ADDR_WRAP_MASK);

    always_comb begin
        addr_next       = addr_reg;
        read_high_next  = read_high_reg;
        write_high_next = write_high_reg;
        rbyte_next      = wbyte_reg;
        cost_next       = COST_DATA_READ;
        if (kind_reg == KIND_READ) begin
            write_high_next = 1'b1;
            if (port_reg == PORT_DATA) begin
                cost_next  = COST_DATA_READ;
                rbyte_next = rdata_reg;
                addr_next  = addr_step;
            end else begin
                cost_next      = COST_ADDR_READ;
                rbyte_next     = read_high_reg ? addr_plus[15:8] : addr_plus[7:0];
                read_high_next = !read_high_reg;
            end
        end else begin
            if (port_reg == PORT_DATA) begin
                cost_next       = COST_DATA_WRITE;
                addr_next       = addr_step;
                write_high_next = 1'b1;
            end else begin
                if (write_high_reg) begin
                    cost_next = COST_ADDR_WRITE_HIGH;
                    addr_next = (addr_reg & LOW_MASK) | {wbyte_reg, 8'h00};
                end else begin
                    cost_next = COST_ADDR_WRITE_LOW;
                    addr_next = (addr_reg & HIGH_MASK) | {8'h00, wbyte_reg};
                end
                write_high_next = !write_high_reg;
                read_high_next  = 1'b1;
            end
        end
    end

    // Store: read on capture, written on commit of a data write.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rdata_reg <= store_mem[addr_reg[ADDR_BITS-1:0]];
        end
        if (cmd.commit && (kind_reg == KIND_WRITE) && (port_reg == PORT_DATA)) begin
            store_mem[addr_reg[ADDR_BITS-1:0]] <= wbyte_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg  <= in_kind;
            port_reg  <= in_port;
            wbyte_reg <= in_write_byte;
        end
        if (cmd.commit) begin
            rbyte_reg <= rbyte_next;
            cost_reg  <= cost_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg       <= 16'h0000;
            read_high_reg  <= 1'b1;
            write_high_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.commit) begin
                addr_reg       <= addr_next;
                read_high_reg  <= read_high_next;
                write_high_reg <= write_high_next;
                out_valid_reg  <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    assign status.out_full = out_valid_reg;
    assign out_valid       = out_valid_reg;
    assign out_read_byte   = rbyte_reg;
    assign out_wait_cost   = cost_reg;

    commit_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");
    data_keeps_bank: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && (port_reg == PORT_DATA)) |=>
            (addr_reg[15:13] == $past(addr_reg[15:13])))
        else $error("data access changed the top address bits");
    addr_write_rearms_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && (kind_reg == KIND_WRITE) && (port_reg == PORT_ADDR)) |=>
            read_high_reg)
        else $error("address write did not rearm the read sequence");
    read_rearms_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && (kind_reg == KIND_READ)) |=> write_high_reg)
        else $error("read did not rearm the write sequence");

endmodule

// ===== rtl/core/grom_port_address_counter_unit.sv =====
// ----------------------------------------------------------------------------
// grom_port_address_counter_unit
// Byte-wide graphics memory port with an auto-incrementing address counter.
// ----------------------------------------------------------------------------
// Channel | Direction | tdata                          | tuser
// s_      | in        | [7:0] write_byte               | [0] kind, [1] port
// m_      | out       | [7:0] read_byte, [12:8] wait   | -
//
// Each beat is first captured, when the store is read at the current address,
// and then committed, when the result is formed and the counter, flags and store are updated.
// A new beat is taken while the previous result still waits in the output
// register; execution holds only while that register is full and m_tready is low.
// Reset clears the address to zero and sets both byte flags; the store is
// not cleared.
// ----------------------------------------------------------------------------
module grom_port_address_counter_unit
    import gpac_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] write_byte
    input  logic [1:0]  s_tuser,   // [0] kind, [1] port
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] read_byte, [12:8] wait_cost, zero pad
);

    gpac_cmd_t    cmd;
    gpac_status_t status;
    logic [7:0]   read_byte;
    logic [4:0]   wait_cost;

    gpac_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gpac_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .in_kind       (s_tuser[0]),
        .in_port       (s_tuser[1]),
        .in_write_byte (s_tdata),
        .m_tready      (m_tready),
        .out_valid     (m_tvalid),
        .out_read_byte (read_byte),
        .out_wait_cost (wait_cost)
    );

    assign m_tdata = {3'b000, wait_cost, read_byte};

endmodule

// ===== verif/tb_grom_port_address_counter_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grom_port_address_counter_unit
// Self-checking bench for the graphics memory port with its address counter.
// Directed tests cover the reset readback, both address wraps, the byte flag
// rules and the field extremes. Random traffic then loads addresses, writes
// bursts, rewinds and reads them back, mixed with broken sequences and noise.
// Each result beat is checked against a predictor of the port kept in the
// bench, under four idling phases across the two channels.
// ----------------------------------------------------------------------------
module tb_grom_port_address_counter_unit;
    import gpac_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_BEATS  = 1050;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [7:0] rd_byte;
        logic [4:0] cost;
    } port_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] write_byte
    logic [1:0]  s_tuser  = 2'b00;   // [0] kind, [1] port
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [7:0] read_byte, [12:8] wait_cost, zero pad

    // Predicted port state.
    logic [15:0] rom_addr    = 16'h0000;
    bit          rd_hi_next  = 1'b1;
    bit          wr_hi_next  = 1'b1;
    logic [7:0]  rom_image   [STORE_SIZE];
    bit          rom_written [STORE_SIZE];

    port_result_t pending_results[$];
    port_result_t head_result;
    logic [15:0]  used_bases[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int cycle_count    = 0;
    int beat_count     = 0;
    int n_data_rd      = 0;
    int n_data_wr      = 0;
    int n_addr_rd      = 0;
    int n_addr_wr      = 0;

    grom_port_address_counter_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // Works out the result of one accepted access and advances the predicted state.
    function automatic port_result_t predict_port_access(input logic kind, input logic port,
                                                         input logic [7:0] wbyte);
        port_result_t res;
        logic [15:0]  plus_one;
        res.rd_byte = wbyte;
        plus_one    = rom_addr + 16'd1;
        if (kind == KIND_READ) begin
            wr_hi_next = 1'b1;
            if (port == PORT_DATA) begin
                res.cost    = COST_DATA_READ;
                res.rd_byte = rom_image[rom_addr[ADDR_BITS-1:0]];
                rom_addr    = (rom_addr & ADDR_KEEP_MASK) | (plus_one & ADDR_WRAP_MASK);
                n_data_rd++;
            end else begin
                res.cost    = COST_ADDR_READ;
                res.rd_byte = rd_hi_next ? plus_one[15:8] : plus_one[7:0];
                rd_hi_next  = !rd_hi_next;
                n_addr_rd++;
            end
        end else if (port == PORT_DATA) begin
            res.cost                              = COST_DATA_WRITE;
            rom_image[rom_addr[ADDR_BITS-1:0]]    = wbyte;
            rom_written[rom_addr[ADDR_BITS-1:0]]  = 1'b1;
            rom_addr = (rom_addr & ADDR_KEEP_MASK) | (plus_one & ADDR_WRAP_MASK);
            wr_hi_next                            = 1'b1;
            n_data_wr++;
        end else begin
            if (wr_hi_next) begin
                res.cost = COST_ADDR_WRITE_HIGH;
                rom_addr = (rom_addr & LOW_MASK) | {wbyte, 8'h00};
            end else begin
                res.cost = COST_ADDR_WRITE_LOW;
                rom_addr = (rom_addr & HIGH_MASK) | {8'h00, wbyte};
            end
            wr_hi_next = !wr_hi_next;
            rd_hi_next = 1'b1;
            n_addr_wr++;
        end
        return res;
    endfunction

    // Sends one beat. Called and left at a falling edge; s_tvalid stays high
    // after acceptance so that the next call either drops it or reuses it.
    task automatic send_access(input logic kind, input logic port, input logic [7:0] wbyte);
        logic use_kind;
        use_kind = kind;
        // A store entry that was never written must not be read, so such a
        // data read is turned into a data write at the same address.
        if (kind == KIND_READ && port == PORT_DATA && !rom_written[rom_addr[ADDR_BITS-1:0]])
            use_kind = KIND_WRITE;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= wbyte;
        s_tuser  <= {port, use_kind};
        do @(posedge aclk); while (!s_tready);
        pending_results = {pending_results, predict_port_access(use_kind, port, wbyte)};
        beat_count++;
        @(negedge aclk);
    endtask

    task automatic load_address(input logic [15:0] addr);
        // An address read restarts the byte sequence if a low byte is pending.
        if (!wr_hi_next)
            send_access(KIND_READ, PORT_ADDR, 8'h00);
        send_access(KIND_WRITE, PORT_ADDR, addr[15:8]);
        send_access(KIND_WRITE, PORT_ADDR, addr[7:0]);
    endtask

    task automatic read_address_back();
        repeat (2) send_access(KIND_READ, PORT_ADDR, 8'($urandom_range(255)));
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Right after reset the address reads back as one, high byte first.
    task automatic test_reset_readback();
        send_access(KIND_READ, PORT_ADDR, 8'hFF);
        send_access(KIND_READ, PORT_ADDR, 8'h00);
    endtask

    // The readback of 0xFFFF wraps to zero, and the counter wraps to 0xE000.
    task automatic test_address_wrap();
        load_address(16'hFFFF);
        send_access(KIND_READ, PORT_ADDR, 8'h00);
        send_access(KIND_WRITE, PORT_DATA, 8'h00);
        send_access(KIND_WRITE, PORT_DATA, 8'hFF);
        send_access(KIND_READ, PORT_ADDR, 8'hFF);
        load_address(16'hFFFF);
        send_access(KIND_READ, PORT_DATA, 8'h00);
        send_access(KIND_READ, PORT_DATA, 8'hFF);
    endtask

    // Bits 12..0 wrap while bits 15..13 hold.
    task automatic test_counter_wrap();
        load_address(16'h3FFF);
        send_access(KIND_WRITE, PORT_DATA, 8'h5A);
        read_address_back();
    endtask

    // Reads and data writes restart the address load; address writes
    // restart the readback.
    task automatic test_flag_rules();
        send_access(KIND_WRITE, PORT_ADDR, 8'hAB);
        send_access(KIND_READ, PORT_ADDR, 8'h00);
        send_access(KIND_WRITE, PORT_ADDR, 8'h34);
        send_access(KIND_WRITE, PORT_ADDR, 8'hC0);
        send_access(KIND_WRITE, PORT_ADDR, 8'h77);
        send_access(KIND_WRITE, PORT_DATA, 8'h01);
        send_access(KIND_WRITE, PORT_ADDR, 8'h66);
    endtask

    // Mostly load / write burst / rewind / read back, with broken loads and noise.
    task automatic test_random_traffic(input int n_beats);
        int          start_count;
        int          choice;
        int          pick;
        int          burst;
        logic [15:0] base;
        start_count = beat_count;
        while (beat_count - start_count < n_beats) begin
            choice = $urandom_range(99);
            if (choice < 70) begin
                pick = $urandom_range(99);
                base = 16'($urandom);
                if (used_bases.size() != 0 && pick < 45)
                    base = used_bases[$urandom_range(used_bases.size() - 1)];
                else if (pick < 70)
                    base[12:3] = '1;
                else if (pick < 78)
                    base[15:3] = '1;
                if (used_bases.size() < 64)
                    used_bases = {used_bases, base};
                burst = $urandom_range(1, 8);
                load_address(base);
                if ($urandom_range(3) != 0)
                    repeat (burst)
                        send_access(KIND_WRITE, PORT_DATA, 8'($urandom_range(255)));
                if ($urandom_range(3) == 0)
                    read_address_back();
                load_address(base);
                repeat (burst) send_access(KIND_READ, PORT_DATA, 8'($urandom_range(255)));
            end else if (choice < 85) begin
                send_access(KIND_WRITE, PORT_ADDR, 8'($urandom_range(255)));
                send_access(1'($urandom_range(1)), 1'($urandom_range(1)),
                            8'($urandom_range(255)));
            end else begin
                send_access(1'($urandom_range(1)), 1'($urandom_range(1)),
                            8'($urandom_range(255)));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("Result beat with nothing expected: m_tdata=%h", m_tdata);
                fail_count++;
            end else begin
                head_result = pending_results.pop_front();
                if (m_tdata[7:0] !== head_result.rd_byte) begin
                    $error("read_byte: expected %0d, actual %0d",
                           head_result.rd_byte, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tdata[12:8] !== head_result.cost) begin
                    $error("wait_cost: expected %0d, actual %0d",
                           head_result.cost, m_tdata[12:8]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        set_idling(0, 0);
        test_reset_readback();
        test_address_wrap();
        test_counter_wrap();
        test_flag_rules();
        wait_results_done();

        set_idling(0, 0);
        test_random_traffic(RANDOM_BEATS / 4);
        wait_results_done();
        set_idling(67, 0);
        test_random_traffic(RANDOM_BEATS / 4);
        wait_results_done();
        set_idling(0, 67);
        test_random_traffic(RANDOM_BEATS / 4);
        wait_results_done();
        set_idling(17, 17);
        test_random_traffic(RANDOM_BEATS / 4);
        wait_results_done();

        $display("Sent %0d beats: %0d data reads, %0d data writes, %0d address reads,",
                 beat_count, n_data_rd, n_data_wr, n_addr_rd);
        $display("%0d address writes; idling phases: none, sender 67%%, receiver 67%%, both 17%%.",
                 n_addr_wr);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
